FILE: src/random_cycle_permutation_engine_top_macros.svh
// Assertion macros used by the permutation engine top level.
`ifndef RANDOM_CYCLE_PERMUTATION_ENGINE_TOP_MACROS_SVH
`define RANDOM_CYCLE_PERMUTATION_ENGINE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCPE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rcpe_pkg.sv
// Package with the field widths, constants and state type of the permutation engine.
package rcpe_pkg;

    // Field widths of the input, result and configuration words.
    localparam int ACT_W  = 2;
    localparam int CNT_W  = 13;
    localparam int IDX_W  = 12;
    localparam int STP_W  = 32;
    localparam int VAL_W  = 12;
    localparam int SEED_W = 64;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_BUILD = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CHASE = 2'd2;

    // Generator constants.
    localparam logic [SEED_W-1:0] SEED_RESET   = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [SEED_W-1:0] SCRAMBLE_MUL = 64'h2545_F491_4F6C_DD1D;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_GEN,
        S_MUL,
        S_MOD,
        S_RDI,
        S_RDJ,
        S_WRI,
        S_WRJ,
        S_CHMOD,
        S_CH_RD,
        S_CH_DAT,
        S_RD,
        S_RD_DAT,
        S_DONE
    } t_state;

endpackage

FILE: src/rcpe_in_if.sv
// Interface of the input channel: one word holds an action and its operands.
interface rcpe_in_if;
    logic                       valid;
    logic                       ready;
    logic [rcpe_pkg::ACT_W-1:0] action;
    logic [rcpe_pkg::CNT_W-1:0] count;
    logic [rcpe_pkg::IDX_W-1:0] index;
    logic [rcpe_pkg::STP_W-1:0] steps;

    modport source (output valid, output action, output count, output index,
                    output steps, input ready);
    modport sink   (input valid, input action, input count, input index,
                    input steps, output ready);
endinterface

FILE: src/rcpe_out_if.sv
// Interface of the result channel: one word per accepted input word.
interface rcpe_out_if;
    logic                       valid;
    logic                       ready;
    logic [rcpe_pkg::VAL_W-1:0] value;
    logic                       ok;

    modport source (output valid, output value, output ok, input ready);
    modport sink   (input valid, input value, input ok, output ready);
endinterface

FILE: src/rcpe_cfg_if.sv
// Interface of the configuration channel that writes the generator seed.
interface rcpe_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [rcpe_pkg::SEED_W-1:0] seed;

    modport source (output valid, output seed, input ready);
    modport sink   (input valid, input seed, output ready);
endinterface

FILE: src/random_cycle_permutation_engine_top.sv
// Top level of the random cycle permutation engine.
//
// i_in carries one word per request: build (count slots into a single random
// cycle), read (one slot by index) or chase (follow the cycle from slot 0 for
// steps hops). Every accepted word gives exactly one word on o_out: value and
// ok, with ok low and value zero for rejected requests. i_cfg writes the
// 64-bit generator seed; it is taken only while the sequencer is idle.
// Requests are handled one at a time; i_in.ready is high whenever the
// sequencer is idle, even while a finished result waits in the output register.
// Chase reduces steps mod count in the remainder unit, then makes one table
// read per hop; build fills count slots, then each swap pays a generator
// step, a split 64-bit multiply, the remainder unit and four accesses on
// the single table read port and write port.
// Reset clears the built flag and length and loads the seed reset value; the
// table itself is not cleared. If the receiver stalls, one result waits in the
// output register and the sequencer holds its next result until that is taken.
`include "random_cycle_permutation_engine_top_macros.svh"

module random_cycle_permutation_engine_top #(
    parameter int DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rcpe_in_if.sink     i_in,
    rcpe_out_if.source  o_out,
    rcpe_cfg_if.sink    i_cfg
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = rcpe_pkg::CNT_W;
    localparam int VW = rcpe_pkg::VAL_W;

    // xorshift step of the generator.
    function automatic logic [63:0] f_xs(input logic [63:0] x);
        logic [63:0] t;
        t = x ^ (x >> 12);
        t = t ^ (t << 25);
        t = t ^ (t >> 27);
        return t;
    endfunction

    rcpe_pkg::t_state r_state, n_state;
    logic          r_built, n_built;
    logic [CW-1:0] r_len, n_len;
    logic [63:0]   r_rng, n_rng;
    logic          r_out_valid, n_out_valid;
    logic          r_div_start, n_div_start;

    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [63:0]   r_acc, n_acc;
    logic [63:0]   r_prod, n_prod;
    logic [1:0]    r_mph, n_mph;
    logic [AW-1:0] r_di, n_di;
    logic [AW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_hops, n_hops;
    logic [rcpe_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [VW-1:0] r_res_val, n_res_val;
    logic          r_res_ok, n_res_ok;
    logic [VW-1:0] r_out_value, n_out_value;
    logic          r_out_ok, n_out_ok;

    logic [31:0]   mul_a, mul_b;
    logic [63:0]   mul_p;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [AW-1:0] ram_wdata, ram_rdata;

    logic          div_done;
    logic [CW-1:0] div_rem;
    logic [CW-1:0] div_dvs;

    logic          idle;

    // Next-slot table; its read port reads every cycle, also while the sequencer writes.
    rcpe_ram #(
        .WIDTH (AW),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Shared remainder unit for swap partners and chase hop counts.
    assign div_dvs = (r_state == rcpe_pkg::S_CHMOD) ? r_len : r_i;

    rcpe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_acc),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // One 32x32 multiplier, stepped over three partial products of x * SCRAMBLE_MUL.
    always_comb begin
        case (r_mph)
            2'd0: begin
                mul_a = r_rng[31:0];
                mul_b = rcpe_pkg::SCRAMBLE_MUL[31:0];
            end
            2'd1: begin
                mul_a = r_rng[63:32];
                mul_b = rcpe_pkg::SCRAMBLE_MUL[31:0];
            end
            default: begin
                mul_a = r_rng[31:0];
                mul_b = rcpe_pkg::SCRAMBLE_MUL[63:32];
            end
        endcase
        mul_p = {32'b0, mul_a} * {32'b0, mul_b};
    end

    assign idle        = (r_state == rcpe_pkg::S_IDLE);
    assign i_in.ready  = idle;
    assign i_cfg.ready = idle;

    // Sequencer: next state, table accesses and datapath updates.
    always_comb begin
        n_state     = r_state;
        n_built     = r_built;
        n_len       = r_len;
        n_rng       = r_rng;
        n_div_start = 1'b0;
        n_cnt       = r_cnt;
        n_fill      = r_fill;
        n_i         = r_i;
        n_j         = r_j;
        n_acc       = r_acc;
        n_prod      = r_prod;
        n_mph       = r_mph;
        n_di        = r_di;
        n_pos       = r_pos;
        n_hops      = r_hops;
        n_idx       = r_idx;
        n_res_val   = r_res_val;
        n_res_ok    = r_res_ok;
        n_out_value = r_out_value;
        n_out_ok    = r_out_ok;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = AW'(r_i);
        ram_wdata   = ram_rdata;
        ram_raddr   = AW'(r_i);

        // The output register drains independently of the sequencer.
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            rcpe_pkg::S_IDLE: begin
                if (i_cfg.valid) begin
                    n_rng = i_cfg.seed;
                end
                if (i_in.valid) begin
                    n_res_val = '0;
                    n_res_ok  = 1'b0;
                    n_state   = rcpe_pkg::S_DONE;
                    case (i_in.action)
                        rcpe_pkg::ACT_BUILD: begin
                            if (i_in.count >= CW'(2) && 32'(i_in.count) <= 32'(DEPTH)) begin
                                n_cnt   = i_in.count;
                                n_fill  = '0;
                                n_state = rcpe_pkg::S_FILL;
                            end
                        end
                        rcpe_pkg::ACT_READ: begin
                            if (r_built && {1'b0, i_in.index} < r_len) begin
                                n_idx   = i_in.index;
                                n_state = rcpe_pkg::S_RD;
                            end
                        end
                        rcpe_pkg::ACT_CHASE: begin
                            if (r_built) begin
                                n_acc       = {32'b0, i_in.steps};
                                n_div_start = 1'b1;
                                n_state     = rcpe_pkg::S_CHMOD;
                            end
                        end
                        default: begin
                            n_state = rcpe_pkg::S_DONE;
                        end
                    endcase
                end
            end

            // Identity fill, one slot per cycle.
            rcpe_pkg::S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_fill);
                ram_wdata = AW'(r_fill);
                n_fill    = r_fill + 1'b1;
                if (r_fill == r_cnt - 1'b1) begin
                    n_i     = r_cnt - 1'b1;
                    n_state = rcpe_pkg::S_GEN;
                end
            end

            // Advance the generator for the next swap.
            rcpe_pkg::S_GEN: begin
                n_rng   = f_xs(r_rng);
                n_mph   = 2'd0;
                n_state = rcpe_pkg::S_MUL;
            end

            // Scramble: low product, then the two cross terms into the upper half.
            rcpe_pkg::S_MUL: begin
                n_prod = mul_p;
                n_mph  = r_mph + 1'b1;
                case (r_mph)
                    2'd0: begin
                        n_acc = r_acc;
                    end
                    2'd1: begin
                        n_acc = r_prod;
                    end
                    2'd2: begin
                        n_acc = {r_acc[63:32] + r_prod[31:0], r_acc[31:0]};
                    end
                    default: begin
                        n_acc       = {r_acc[63:32] + r_prod[31:0], r_acc[31:0]};
                        n_div_start = 1'b1;
                        n_state     = rcpe_pkg::S_MOD;
                    end
                endcase
            end

            // Swap partner j = scrambled output mod i.
            rcpe_pkg::S_MOD: begin
                if (div_done) begin
                    n_j     = div_rem;
                    n_state = rcpe_pkg::S_RDI;
                end
            end

            rcpe_pkg::S_RDI: begin
                ram_raddr = AW'(r_i);
                n_state   = rcpe_pkg::S_RDJ;
            end

            rcpe_pkg::S_RDJ: begin
                ram_raddr = AW'(r_j);
                n_di      = ram_rdata;
                n_state   = rcpe_pkg::S_WRI;
            end

            // Slot i takes the old content of slot j.
            rcpe_pkg::S_WRI: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_i);
                ram_wdata = ram_rdata;
                n_state   = rcpe_pkg::S_WRJ;
            end

            // Slot j takes the old content of slot i; close the loop at i equal to one.
            rcpe_pkg::S_WRJ: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_j);
                ram_wdata = r_di;
                if (r_i == CW'(1)) begin
                    n_len     = r_cnt;
                    n_built   = 1'b1;
                    n_res_val = '0;
                    n_res_ok  = 1'b1;
                    n_state   = rcpe_pkg::S_DONE;
                end else begin
                    n_i     = r_i - 1'b1;
                    n_state = rcpe_pkg::S_GEN;
                end
            end

            // Chase: reduce the step count modulo the cycle length first.
            rcpe_pkg::S_CHMOD: begin
                if (div_done) begin
                    n_hops = div_rem;
                    n_pos  = '0;
                    if (div_rem == '0) begin
                        n_res_val = '0;
                        n_res_ok  = 1'b1;
                        n_state   = rcpe_pkg::S_DONE;
                    end else begin
                        n_state = rcpe_pkg::S_CH_RD;
                    end
                end
            end

            rcpe_pkg::S_CH_RD: begin
                ram_raddr = r_pos;
                n_state   = rcpe_pkg::S_CH_DAT;
            end

            rcpe_pkg::S_CH_DAT: begin
                n_pos  = ram_rdata;
                n_hops = r_hops - 1'b1;
                if (r_hops == CW'(1)) begin
                    n_res_val = VW'(ram_rdata);
                    n_res_ok  = 1'b1;
                    n_state   = rcpe_pkg::S_DONE;
                end else begin
                    n_state = rcpe_pkg::S_CH_RD;
                end
            end

            rcpe_pkg::S_RD: begin
                ram_raddr = AW'(r_idx);
                n_state   = rcpe_pkg::S_RD_DAT;
            end

            rcpe_pkg::S_RD_DAT: begin
                n_res_val = VW'(ram_rdata);
                n_res_ok  = 1'b1;
                n_state   = rcpe_pkg::S_DONE;
            end

            // Hand the result to the output register once it is free.
            rcpe_pkg::S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res_val;
                    n_out_ok    = r_res_ok;
                    n_state     = rcpe_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = rcpe_pkg::S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcpe_pkg::S_IDLE;
            r_built     <= 1'b0;
            r_len       <= '0;
            r_rng       <= rcpe_pkg::SEED_RESET;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_built     <= n_built;
            r_len       <= n_len;
            r_rng       <= n_rng;
            r_out_valid <= n_out_valid;
            r_div_start <= n_div_start;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_fill      <= n_fill;
        r_i         <= n_i;
        r_j         <= n_j;
        r_acc       <= n_acc;
        r_prod      <= n_prod;
        r_mph       <= n_mph;
        r_di        <= n_di;
        r_pos       <= n_pos;
        r_hops      <= n_hops;
        r_idx       <= n_idx;
        r_res_val   <= n_res_val;
        r_res_ok    <= n_res_ok;
        r_out_value <= n_out_value;
        r_out_ok    <= n_out_ok;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.value = r_out_value;
    assign o_out.ok    = r_out_ok;

    // Sattolo partners always lie strictly below the current slot.
    `RCPE_ASSERT_SAME(a_swap_order, i_clk, i_rst_n, r_state == rcpe_pkg::S_RDI, r_j < r_i, "swap partner not below slot")
    // A built table always has a legal length.
    `RCPE_ASSERT_SAME(a_built_len, i_clk, i_rst_n, r_built, r_len >= CW'(2) && 32'(r_len) <= 32'(DEPTH), "built table has illegal length")
    // A hop is only issued while hops remain.
    `RCPE_ASSERT_SAME(a_hops_live, i_clk, i_rst_n, r_state == rcpe_pkg::S_CH_RD, r_hops != '0, "chase hop issued with no hops left")
    // The remainder unit only reports to a state waiting for it.
    `RCPE_ASSERT_SAME(a_div_owner, i_clk, i_rst_n, div_done, r_state == rcpe_pkg::S_MOD || r_state == rcpe_pkg::S_CHMOD, "remainder done outside a wait state")
    // A finished result lands in the output register and frees the sequencer.
    `RCPE_ASSERT_NEXT(a_result_out, i_clk, i_rst_n, r_state == rcpe_pkg::S_DONE && (!r_out_valid || o_out.ready), r_out_valid && r_state == rcpe_pkg::S_IDLE, "result not delivered to output register")

endmodule

FILE: src/rcpe_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module rcpe_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/rcpe_div.sv
// Iterative restoring divider that returns the remainder of a 64-bit dividend.
module rcpe_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [63:0]                i_dividend,
    input  logic [rcpe_pkg::CNT_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [rcpe_pkg::CNT_W-1:0] o_rem
);

    localparam int DVD_W = 64;
    localparam int CW    = $clog2(DVD_W);

    logic                       r_busy;
    logic                       r_done;
    logic [CW-1:0]              r_cnt;
    logic [DVD_W-1:0]           r_dvd;
    logic [rcpe_pkg::CNT_W-1:0] r_dvs;
    logic [rcpe_pkg::CNT_W-1:0] r_rem;

    logic [rcpe_pkg::CNT_W:0]   trial;
    logic [rcpe_pkg::CNT_W-1:0] n_rem;

    // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1]};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = rcpe_pkg::CNT_W'(trial - {1'b0, r_dvs});
        end else begin
            n_rem = rcpe_pkg::CNT_W'(trial);
        end
    end

    // Control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CW'(DVD_W - 1);
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the random cycle permutation engine.
`timescale 1ns / 1ps

module tb;

    localparam int NUM_SLOTS      = 4096;
    localparam int N_DIRECTED     = 25;
    localparam int N_PHASES       = 5;
    localparam int WORDS_PER_PHASE = 15;
    localparam int LONG_HOLD      = 40000;
    localparam int TAIL_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000000;
    localparam int MAX_REPORTS    = 10;

    // Action code that the block must reject.
    localparam logic [rcpe_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

    // One request word, with an optional hand-typed answer.
    typedef struct packed {
        logic [rcpe_pkg::ACT_W-1:0] action;
        logic [rcpe_pkg::CNT_W-1:0] count;
        logic [rcpe_pkg::IDX_W-1:0] index;
        logic [rcpe_pkg::STP_W-1:0] steps;
        logic                       typed;
        logic [rcpe_pkg::VAL_W-1:0] exp_value;
        logic                       exp_ok;
    } t_stim_row;

    // One answer word as it leaves the block.
    typedef struct packed {
        logic [rcpe_pkg::VAL_W-1:0] value;
        logic                       ok;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rcpe_in_if  in_ch ();
    rcpe_out_if out_ch ();
    rcpe_cfg_if cfg_ch ();

    random_cycle_permutation_engine_top #(
        .DEPTH (NUM_SLOTS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the slot table, cycle length, built flag and generator.
    logic [rcpe_pkg::IDX_W-1:0]  slot_model [NUM_SLOTS];
    logic [rcpe_pkg::CNT_W-1:0]  len_model;
    logic                        built_model;
    logic [rcpe_pkg::SEED_W-1:0] gen_model;

    t_answer   answer_q [$];
    t_stim_row directed_rows [N_DIRECTED];
    int        error_count = 0;
    int        burst_left = 0;
    bit        hold_off_req = 1'b0;

    // Advance the xorshift state and return the scrambled output.
    function automatic logic [rcpe_pkg::SEED_W-1:0] gen_advance();
        logic [rcpe_pkg::SEED_W-1:0] x;
        x = gen_model;
        x ^= x >> 12;
        x ^= x << 25;
        x ^= x >> 27;
        gen_model = x;
        return x * rcpe_pkg::SCRAMBLE_MUL;
    endfunction

    // Apply one accepted word to the shadow state and return the answer it gives.
    function automatic t_answer predict_answer(input t_stim_row r);
        t_answer                    a;
        int unsigned                i;
        int unsigned                j;
        int unsigned                hops;
        logic [rcpe_pkg::IDX_W-1:0] t;
        logic [rcpe_pkg::IDX_W-1:0] p;
        a = '0;
        case (r.action)
            rcpe_pkg::ACT_BUILD: begin
                if (r.count >= 2 && r.count <= NUM_SLOTS) begin
                    for (i = 0; i < r.count; i++) slot_model[i] = rcpe_pkg::IDX_W'(i);
                    // Sattolo's loop: partner strictly below i gives one cycle.
                    for (i = r.count - 1; i > 0; i--) begin
                        j = 32'(gen_advance() % 64'(i));
                        t = slot_model[i];
                        slot_model[i] = slot_model[j];
                        slot_model[j] = t;
                    end
                    len_model = r.count;
                    built_model = 1'b1;
                    a.ok = 1'b1;
                end
            end
            rcpe_pkg::ACT_READ: begin
                if (built_model && r.index < len_model) begin
                    a.value = slot_model[r.index];
                    a.ok = 1'b1;
                end
            end
            rcpe_pkg::ACT_CHASE: begin
                if (built_model && len_model >= 1) begin
                    // A single cycle repeats every len_model hops.
                    hops = r.steps % len_model;
                    p = '0;
                    for (i = 0; i < hops; i++) p = slot_model[p];
                    a.value = p;
                    a.ok = 1'b1;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    // Offer one word in bursts with random gaps, then record its answer.
    task automatic issue_word(input t_stim_row r);
        t_answer a;
        int      gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        in_ch.valid  <= 1'b1;
        in_ch.action <= r.action;
        in_ch.count  <= r.count;
        in_ch.index  <= r.index;
        in_ch.steps  <= r.steps;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        a = predict_answer(r);
        if (r.typed) begin
            a.value = r.exp_value;
            a.ok    = r.exp_ok;
        end
        answer_q.push_back(a);
    endtask

    // Stop offering and wait until every outstanding answer has come back.
    task automatic settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the seed register; the generator restarts from it.
    task automatic load_seed(input logic [rcpe_pkg::SEED_W-1:0] s);
        cfg_ch.valid <= 1'b1;
        cfg_ch.seed  <= s;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        gen_model = s;
    endtask

    // Mostly reads and chases, with some builds, refused counts and unused codes.
    task automatic pick_request(input bit force_build, output t_stim_row r);
        int roll;
        int span;
        r = '0;
        r.count = rcpe_pkg::CNT_W'($urandom);
        r.index = rcpe_pkg::IDX_W'($urandom);
        r.steps = $urandom;
        span = int'(len_model);
        roll = force_build ? 0 : $urandom_range(0, 99);
        if (roll < 20) begin
            r.action = rcpe_pkg::ACT_BUILD;
            if (force_build)
                r.count = rcpe_pkg::CNT_W'($urandom_range(2, 16));
            else if ($urandom_range(0, 9) == 0)
                r.count = rcpe_pkg::CNT_W'($urandom_range(65, 480));
            else
                r.count = rcpe_pkg::CNT_W'($urandom_range(2, 64));
        end else if (roll < 25) begin
            // Counts that must be refused.
            r.action = rcpe_pkg::ACT_BUILD;
            r.count = ($urandom_range(0, 1) == 0)
                      ? rcpe_pkg::CNT_W'($urandom_range(0, 1))
                      : rcpe_pkg::CNT_W'($urandom_range(NUM_SLOTS + 1, 8191));
        end else if (roll < 62) begin
            r.action = rcpe_pkg::ACT_READ;
            if (built_model && $urandom_range(0, 4) != 0)
                r.index = rcpe_pkg::IDX_W'($urandom_range(0, span - 1));
        end else if (roll < 95) begin
            r.action = rcpe_pkg::ACT_CHASE;
            if ($urandom_range(0, 1) == 0)
                r.steps = $urandom_range(0, 3 * span + 2);
        end else begin
            r.action = ACT_UNUSED;
        end
    endtask

    // Record a failure; only the first few are printed.
    task automatic record_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    // Answer checker and watchdog on inactivity.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n === 1'b1 && out_ch.valid && out_ch.ready) begin
            if (answer_q.size() == 0) begin
                record_error($sformatf("unexpected word value=%0d ok=%0d",
                                       out_ch.value, out_ch.ok));
            end else begin
                want = answer_q.pop_front();
                if (out_ch.ok !== want.ok)
                    record_error($sformatf("ok expected %0d, got %0d", want.ok, out_ch.ok));
                if (out_ch.value !== want.value)
                    record_error($sformatf("value expected %0d, got %0d",
                                           want.value, out_ch.value));
            end
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d answers outstanding", answer_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: ready follows a changing pattern, with one long hold-off on request.
    initial begin
        int mode;
        int left;
        int tick;
        mode = 0;
        left = 0;
        tick = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(10, 150);
            end
            left--;
            tick++;
            case (mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                default: out_ch.ready <= tick[2];
            endcase
        end
    end

    // Stimulus: reset, the directed rows, then random phases under several seeds.
    initial begin
        t_stim_row r;
        int        ph;
        int        n;
        in_ch.valid  = 1'b0;
        in_ch.action = rcpe_pkg::ACT_BUILD;
        in_ch.count  = '0;
        in_ch.index  = '0;
        in_ch.steps  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.seed  = '0;
        i_rst_n      = 1'b0;
        len_model    = '0;
        built_model  = 1'b0;
        gen_model    = rcpe_pkg::SEED_RESET;

        // action, count, index, steps, typed, value, ok
        directed_rows = '{
            '{rcpe_pkg::ACT_READ,  13'd0,    12'd0,    32'd0,         1'b1, 12'd0, 1'b0},
            '{rcpe_pkg::ACT_CHASE, 13'd0,    12'd0,    32'd5,         1'b1, 12'd0, 1'b0},
            '{ACT_UNUSED,          13'd8191, 12'd4095, 32'hFFFF_FFFF, 1'b1, 12'd0, 1'b0},
            '{rcpe_pkg::ACT_BUILD, 13'd0,    12'd0,    32'd0,         1'b1, 12'd0, 1'b0},
            '{rcpe_pkg::ACT_BUILD, 13'd1,    12'd0,    32'd0,         1'b1, 12'd0, 1'b0},
            '{rcpe_pkg::ACT_BUILD, 13'd4097, 12'd0,    32'd0,         1'b1, 12'd0, 1'b0},
            '{rcpe_pkg::ACT_BUILD, 13'd8191, 12'd0,    32'd0,         1'b1, 12'd0, 1'b0},
            '{rcpe_pkg::ACT_READ,  13'd0,    12'd4095, 32'd0,         1'b1, 12'd0, 1'b0},
            '{rcpe_pkg::ACT_BUILD, 13'd2,    12'd0,    32'd0,         1'b1, 12'd0, 1'b1},
            '{rcpe_pkg::ACT_READ,  13'd0,    12'd0,    32'd0,         1'b1, 12'd1, 1'b1},
            '{rcpe_pkg::ACT_READ,  13'd0,    12'd1,    32'd0,         1'b1, 12'd0, 1'b1},
            '{rcpe_pkg::ACT_READ,  13'd0,    12'd2,    32'd0,         1'b1, 12'd0, 1'b0},
            '{rcpe_pkg::ACT_READ,  13'd0,    12'd4095, 32'd0,         1'b1, 12'd0, 1'b0},
            '{rcpe_pkg::ACT_CHASE, 13'd0,    12'd0,    32'd0,         1'b1, 12'd0, 1'b1},
            '{rcpe_pkg::ACT_CHASE, 13'd0,    12'd0,    32'hFFFF_FFFF, 1'b1, 12'd1, 1'b1},
            '{rcpe_pkg::ACT_BUILD, 13'd4096, 12'd0,    32'd0,         1'b1, 12'd0, 1'b1},
            '{rcpe_pkg::ACT_READ,  13'd0,    12'd4095, 32'd0,         1'b0, 12'd0, 1'b0},
            '{rcpe_pkg::ACT_READ,  13'd0,    12'd0,    32'd0,         1'b0, 12'd0, 1'b0},
            '{rcpe_pkg::ACT_CHASE, 13'd0,    12'd0,    32'hFFFF_FFFF, 1'b0, 12'd0, 1'b0},
            '{rcpe_pkg::ACT_CHASE, 13'd0,    12'd0,    32'd4096,      1'b1, 12'd0, 1'b1},
            '{rcpe_pkg::ACT_CHASE, 13'd0,    12'd0,    32'd1,         1'b0, 12'd0, 1'b0},
            '{ACT_UNUSED,          13'd0,    12'd0,    32'd0,         1'b1, 12'd0, 1'b0},
            '{rcpe_pkg::ACT_BUILD, 13'd5,    12'd0,    32'd0,         1'b1, 12'd0, 1'b1},
            '{rcpe_pkg::ACT_CHASE, 13'd0,    12'd0,    32'd3,         1'b0, 12'd0, 1'b0},
            '{rcpe_pkg::ACT_READ,  13'd0,    12'd4,    32'd0,         1'b0, 12'd0, 1'b0}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) issue_word(directed_rows[k]);

        // Each phase restarts the generator from a new seed, extremes first.
        for (ph = 0; ph < N_PHASES; ph++) begin
            settle();
            case (ph)
                0: load_seed(64'd1);
                1: load_seed('1);
                2: load_seed('0);
                default: load_seed({$urandom, $urandom});
            endcase
            // The receiver holds off while words keep coming, so the block backs up.
            if (ph == 1) hold_off_req = 1'b1;
            for (n = 0; n < WORDS_PER_PHASE; n++) begin
                pick_request(n == 0, r);
                issue_word(r);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && answer_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
